// ===== sv/pole_pkg.sv =====
// ----------------------------------------------------------------------------
// pole_pkg
// types and constants shared by the positional ordered list engine
// ----------------------------------------------------------------------------
package pole_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOCATE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } pole_op_t;

  // request transaction
  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         position;
    logic signed [31:0] value;
  } pole_in_t;

  // result transaction
  typedef struct packed {
    logic               ok;
    logic signed [31:0] element;
    logic [4:0]         found_position;
    logic [4:0]         length;
    logic               empty_res;
  } pole_out_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } pole_cmd_t;

  // search token walking down the chain
  typedef struct packed {
    logic               active;
    logic               fetch;   // get or delete: read at a position
    logic               del;     // delete: shift down once the token leaves
    logic               ok;
    logic               hit;     // locate already matched
    logic signed [31:0] elem;
    logic [4:0]         fpos;
  } pole_tok_t;

endpackage

// ===== sv/pole_cell.sv =====
// ----------------------------------------------------------------------------
// pole_cell
// one list slot: holds an element, shifts with its neighbors, serves the token
// ----------------------------------------------------------------------------
module pole_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pole_pkg::pole_cmd_t  cmd,
  input  logic [IDX_W-1:0]     pos0,
  input  logic signed [31:0]   value,
  input  logic [CNT_W-1:0]     count,
  input  logic signed [31:0]   left,
  input  logic signed [31:0]   right,
  input  pole_pkg::pole_tok_t  tok_in,
  output logic signed [31:0]   data,
  output pole_pkg::pole_tok_t  tok_out
);
  import pole_pkg::*;

  localparam logic [IDX_W-1:0] IDX   = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
  localparam logic [4:0]       FPOS  = 5'(INDEX + 1);

  logic signed [31:0] data_q;
  logic signed [31:0] data_next;
  pole_tok_t          tok_q;
  pole_tok_t          tok_next;

  // slot update for insert and delete
  always_comb begin
    priority if (cmd.ins && (IDX > pos0)) begin
      data_next = left;
    end else if (cmd.ins && (IDX == pos0)) begin
      data_next = value;
    end else if (cmd.del && (IDX >= pos0)) begin
      data_next = right;
    end else begin
      data_next = data_q;
    end
  end

  // token service
  always_comb begin
    tok_next = tok_in;
    if (tok_in.active) begin
      if (tok_in.fetch) begin
        if (tok_in.ok && (pos0 == IDX)) begin
          tok_next.elem = data_q;
        end
      end else if (!tok_in.hit && (count > IDX_C) && (data_q == value)) begin
        tok_next.hit  = 1'b1;
        tok_next.fpos = FPOS;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_q <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.active <= 1'b0;
    end else begin
      tok_q <= tok_next;
    end
  end

  assign data    = data_q;
  assign tok_out = tok_q;

endmodule

// ===== sv/positional_ordered_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_unit
// bounded ordered list of signed 32-bit elements addressed by 1-based position
// ----------------------------------------------------------------------------
// usage
//   a request transaction is taken on a rising edge with start high and busy
//   low; it carries insert, delete, locate, get or clear
//   every request yields one result transaction, shown for exactly one cycle
//   with strobe high; the receiver has no way to hold it off
// latency and throughput
//   insert, clear and unknown codes: result in the cycle after the request,
//   busy stays low, so one such request per cycle
//   get, delete and locate: a token walks the chain of DEPTH cells one cell
//   per cycle and the result shows as it leaves the last cell; busy is high
//   from the request until that result, so no new request is taken during a
//   walk; a delete shifts the chain down on the edge the token leaves the last cell
//   the walk length is set by the cell chain, one compare per cell per cycle
// reset
//   synchronous reset empties the list and drops any token in flight;
//   element slots keep whatever they held and are read only once written
// ----------------------------------------------------------------------------
module positional_ordered_list_engine_unit #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pole_pkg::pole_in_t   request,
  output logic                 strobe,
  output pole_pkg::pole_out_t  result
);
  import pole_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // compare width wide enough for both position and count plus one
  localparam int W  = ((CW > 6) ? CW : 6) + 1;

  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  // control registers
  logic          busy_q;
  logic          busy_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          strobe_q;
  logic          strobe_next;

  // held request fields while the token walks
  logic [IW-1:0]      pos0_q;
  logic signed [31:0] key_q;
  pole_tok_t          launch;
  pole_tok_t          launch_next;

  pole_out_t rslt;
  pole_out_t rslt_next;

  // request decode
  logic          accept;
  logic [W-1:0]  pos_w;
  logic [W-1:0]  cnt_w;
  logic [W-1:0]  pos_m1;
  logic [IW-1:0] pos0_live;
  logic          ins_ok;
  logic          in_range;
  logic          is_walk;

  // cell buses
  pole_cmd_t          cmd;
  logic [IW-1:0]      pos0_bus;
  logic signed [31:0] value_bus;
  logic signed [31:0] cell_data [DEPTH];
  pole_tok_t          cell_tok  [DEPTH];
  pole_tok_t          last_tok;

  assign accept    = start && !busy_q;
  assign pos_w     = W'(request.position);
  assign cnt_w     = W'(count);
  assign pos_m1    = pos_w - W'(1);
  assign pos0_live = pos_m1[IW-1:0];

  // insert needs room and a position from 1 to length+1
  assign ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + W'(1)) && (count < FULL);
  // delete and get need a position from 1 to length
  assign in_range = (pos_w != '0) && (pos_w <= cnt_w);

  assign is_walk = (request.operation == OP_DELETE) ||
                   (request.operation == OP_GET) ||
                   (request.operation == OP_LOCATE);

  assign last_tok = cell_tok[DEPTH-1];

  // broadcasts: live request when idle, held request during a walk
  assign pos0_bus  = busy_q ? pos0_q : pos0_live;
  assign value_bus = busy_q ? key_q  : request.value;

  // insert shifts on the request edge, delete when the token comes out
  assign cmd.ins = accept && (request.operation == OP_INSERT) && ins_ok;
  assign cmd.del = last_tok.active && last_tok.del && last_tok.ok;

  // next count
  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (accept && (request.operation == OP_CLEAR)) begin
      count_next = '0;
    end else if (cmd.del) begin
      count_next = count - CW'(1);
    end
  end

  // token launch and busy flag
  always_comb begin
    launch_next        = launch;
    launch_next.active = 1'b0;
    busy_next          = busy_q;
    if (accept && is_walk) begin
      launch_next.active = 1'b1;
      launch_next.fetch  = (request.operation != OP_LOCATE);
      launch_next.del    = (request.operation == OP_DELETE);
      launch_next.ok     = (request.operation == OP_LOCATE) ? 1'b1 : in_range;
      launch_next.hit    = 1'b0;
      launch_next.elem   = '0;
      launch_next.fpos   = '0;
      busy_next          = 1'b1;
    end else if (last_tok.active) begin
      busy_next = 1'b0;
    end
  end

  // result transaction
  always_comb begin
    rslt_next                = rslt;
    strobe_next              = 1'b0;
    rslt_next.length         = 5'(count_next);
    rslt_next.empty_res      = (count_next == '0);
    if (last_tok.active) begin
      strobe_next              = 1'b1;
      rslt_next.ok             = last_tok.ok;
      rslt_next.element        = last_tok.elem;
      rslt_next.found_position = last_tok.fpos;
    end else if (accept && !is_walk) begin
      strobe_next              = 1'b1;
      rslt_next.element        = '0;
      rslt_next.found_position = '0;
      unique case (request.operation)
        OP_INSERT: rslt_next.ok = ins_ok;
        OP_CLEAR:  rslt_next.ok = 1'b1;
        default:   rslt_next.ok = 1'b0;  // undefined codes leave the list alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q   <= 1'b0;
      count    <= '0;
      strobe_q <= 1'b0;
    end else begin
      busy_q   <= busy_next;
      count    <= count_next;
      strobe_q <= strobe_next;
    end
  end

  // token launch register, only its valid bit is cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      launch.active <= 1'b0;
    end else begin
      launch <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    rslt <= rslt_next;
    if (accept && is_walk) begin
      pos0_q <= pos0_live;
      key_q  <= request.value;
    end
  end

  // chain of cells, cell 0 holds position 1
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;
    pole_tok_t          tok_d;

    if (g == 0) begin : g_head
      assign left_d = '0;
      assign tok_d  = launch;
    end else begin : g_body
      assign left_d = cell_data[g-1];
      assign tok_d  = cell_tok[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_next
      assign right_d = cell_data[g+1];
    end

    pole_cell #(
      .INDEX (g),
      .IDX_W (IW),
      .CNT_W (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .pos0    (pos0_bus),
      .value   (value_bus),
      .count   (count),
      .left    (left_d),
      .right   (right_d),
      .tok_in  (tok_d),
      .data    (cell_data[g]),
      .tok_out (cell_tok[g])
    );
  end

  assign busy   = busy_q;
  assign strobe = strobe_q;
  assign result = rslt;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the positional ordered list engine against a cycle-free shadow list:
// every accepted operation is replayed on the shadow, and each result
// transaction is compared field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module testbench;
  import pole_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int LIST_DEPTH     = 16;
  localparam int RESET_CYCLES   = 8;
  localparam int QUIET_LIMIT    = 1000;
  localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 4;
  localparam int PHASE_ITEMS    = 125;

  // codes the engine has no operation for
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // two shadow lists: one tracks what has been queued, one what was accepted
  localparam int PLANNED  = 0;
  localparam int ACCEPTED = 1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  pole_in_t  request = '0;
  logic      strobe;
  pole_out_t result;

  logic signed [31:0] shadow_cells [2][LIST_DEPTH];
  int                 shadow_len [2] = '{0, 0};

  pole_in_t  pending_ops [$];
  pole_out_t awaited_results [$];
  pole_out_t want;
  bit        took = 1'b0;
  int        idle_pct = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        idle_plan [4] = '{0, 68, 27, 0};

  positional_ordered_list_engine_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // apply one operation to a shadow list and return the result it must give
  function automatic pole_out_t list_step(input int view, input pole_in_t req);
    pole_out_t r;
    int        n;
    int        p;
    int        k;
    r = '0;
    n = shadow_len[view];
    p = req.position;
    case (req.operation)
      OP_INSERT: begin
        if (p >= 1 && p <= n + 1 && n < LIST_DEPTH) begin
          for (k = n; k >= p; k--) shadow_cells[view][k] = shadow_cells[view][k - 1];
          shadow_cells[view][p - 1] = req.value;
          n++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= n) begin
          r.element = shadow_cells[view][p - 1];
          for (k = p; k < n; k++) shadow_cells[view][k - 1] = shadow_cells[view][k];
          n--;
          r.ok = 1'b1;
        end
      end
      OP_LOCATE: begin
        r.ok = 1'b1;
        for (k = 0; k < n; k++) begin
          if (r.found_position == 0 && shadow_cells[view][k] == req.value)
            r.found_position = 5'(k + 1);
        end
      end
      OP_GET: begin
        if (p >= 1 && p <= n) begin
          r.element = shadow_cells[view][p - 1];
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        n = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    shadow_len[view] = n;
    r.length = 5'(n);
    r.empty_res = (n == 0);
    return r;
  endfunction

  task automatic queue_op(input logic [2:0] op, input logic [5:0] pos,
                          input logic signed [31:0] val);
    pole_in_t item;
    item.operation = op;
    item.position  = pos;
    item.value     = val;
    pending_ops.push_back(item);
    void'(list_step(PLANNED, item));
  endtask

  // values: often ones already held so locate hits, plus the extremes
  function automatic logic signed [31:0] pick_value();
    int len;
    int sel;
    len = shadow_len[PLANNED];
    sel = $urandom_range(0, 9);
    if (sel == 0 && len > 0) return shadow_cells[PLANNED][$urandom_range(0, len - 1)];
    if (sel <= 3) return 32'($urandom_range(0, 7)) - 4;
    if (sel == 4) return VAL_MIN;
    if (sel == 5) return VAL_MAX;
    return $urandom;
  endfunction

  task automatic run_random(input int target);
    int         done;
    int         kind;
    int         sel;
    int         len;
    int         reps;
    int         k;
    logic [2:0] op;
    logic [5:0] pos;
    done = 0;
    while (done < target) begin
      kind = $urandom_range(0, 99);
      len  = shadow_len[PLANNED];
      if (kind < 12) begin
        // empty the list and grow it to near or past full
        queue_op(OP_CLEAR, 6'($urandom_range(0, 63)), $urandom);
        reps = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 3);
        for (k = 0; k < reps; k++)
          queue_op(OP_INSERT, 6'($urandom_range(1, shadow_len[PLANNED] + 1)), pick_value());
        done += reps + 1;
      end else if (kind < 90) begin
        sel = $urandom_range(0, 99);
        if (sel < 32) begin
          op  = OP_INSERT;
          pos = 6'($urandom_range(1, len + 1));
        end else begin
          if (sel < 52)      op = OP_DELETE;
          else if (sel < 72) op = OP_LOCATE;
          else if (sel < 96) op = OP_GET;
          else               op = OP_CLEAR;
          pos = 6'($urandom_range(1, (len > 0) ? len : 1));
        end
        // now and then a position anywhere in the field
        if ($urandom_range(0, 9) == 0) pos = 6'($urandom_range(0, 63));
        queue_op(op, pos, pick_value());
        done++;
      end else begin
        op = 3'($urandom_range(0, 7));
        queue_op(op, 6'($urandom_range(0, 63)), $urandom);
        if (op <= OP_CLEAR) done++;
      end
    end
  endtask

  // wait until every queued transaction has been taken and answered
  task automatic settle();
    while (pending_ops.size() != 0 || start || awaited_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic flag_field(input string field, input logic [31:0] want_v,
                            input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    end
  endtask

  // driver: new request on the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        request <= pending_ops.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict for the request taken at this edge
  always @(posedge clk) begin
    took = start && !busy && !rst;
    if (!rst && strobe) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, actual %h", $time, result);
      end else begin
        want = awaited_results.pop_front();
        flag_field("ok", 32'(want.ok), 32'(result.ok));
        flag_field("element", want.element, result.element);
        flag_field("found_position", 32'(want.found_position), 32'(result.found_position));
        flag_field("length", 32'(want.length), 32'(result.length));
        flag_field("empty_res", 32'(want.empty_res), 32'(result.empty_res));
      end
    end
    if (took) awaited_results.push_back(list_step(ACCEPTED, request));

    // watchdog on cycles where no transaction moves either way
    if (took || strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, bad positions, extremes, reserved codes, clear
    queue_op(OP_GET,    6'd1,  32'sd0);
    queue_op(OP_DELETE, 6'd1,  32'sd0);
    queue_op(OP_LOCATE, 6'd0,  32'sd0);
    queue_op(OP_INSERT, 6'd0,  32'sd5);
    queue_op(OP_INSERT, 6'd2,  32'sd5);
    queue_op(OP_INSERT, 6'd1,  VAL_MIN);
    queue_op(OP_INSERT, 6'd2,  VAL_MAX);
    queue_op(OP_INSERT, 6'd1,  -32'sd1);
    queue_op(OP_INSERT, 6'd63, 32'sd7);
    queue_op(OP_GET,    6'd63, 32'sd0);
    queue_op(OP_DELETE, 6'd4,  32'sd0);
    queue_op(OP_LOCATE, 6'd0,  VAL_MAX);
    queue_op(OP_LOCATE, 6'd3,  32'sd12345);
    queue_op(OP_GET,    6'd2,  32'sd0);
    queue_op(OP_INSERT, 6'd4,  -32'sd1);
    queue_op(OP_LOCATE, 6'd0,  -32'sd1);
    queue_op(OP_DELETE, 6'd2,  32'sd0);
    queue_op(OP_DELETE, 6'd3,  32'sd0);
    queue_op(OP_RSVD_LO, 6'd1, 32'sd0);
    queue_op(OP_RSVD_HI, 6'd63, VAL_MIN);
    queue_op(OP_CLEAR,  6'd0,  32'sd0);
    queue_op(OP_GET,    6'd1,  32'sd0);
    queue_op(OP_CLEAR,  6'd63, VAL_MAX);
    settle();

    // random phases with different sender idling
    foreach (idle_plan[i]) begin
      idle_pct = idle_plan[i];
      run_random(PHASE_ITEMS);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
